### src/rqct_pkg.sv
// rqct_pkg: shared types and constants for the replica quorum commit tracker.
// Used by rqct_slot_mem, rqct_scan and replica_quorum_commit_tracker.
// No dependencies.
package rqct_pkg;

    localparam int OFFSET_W     = 63;
    localparam int ASM_W        = 56;
    localparam int ASM_CNT_W    = 3;
    localparam int QUORUM_W     = 5;
    localparam int ACTIVE_W     = 5;
    localparam int BEACON_BYTES = 8;

    localparam logic [OFFSET_W-1:0]  OFFSET_MAX = {OFFSET_W{1'b1}};
    localparam logic [QUORUM_W-1:0]  QUORUM_RST = QUORUM_W'(1);
    localparam logic [ASM_CNT_W-1:0] LAST_BYTE  = ASM_CNT_W'(BEACON_BYTES - 1);

    // item kinds
    localparam logic [1:0] MODE_BEACON     = 2'd0;
    localparam logic [1:0] MODE_CONNECT    = 2'd1;
    localparam logic [1:0] MODE_DISCONNECT = 2'd2;
    localparam logic [1:0] MODE_SYNC       = 2'd3;

    // one slot's stored record
    typedef struct packed {
        logic [OFFSET_W-1:0]  offset;
        logic [ASM_W-1:0]     asm_bytes;
        logic [ASM_CNT_W-1:0] asm_count;
    } rqct_entry_t;

    // scan accumulator control
    typedef struct packed {
        logic clear;
        logic take;
        logic member;
    } rqct_scan_ctl_t;

endpackage

### src/replica_quorum_commit_tracker.sv
// replica_quorum_commit_tracker: top level, control sequencer, slot flags, output register.
// Depends on rqct_pkg, rqct_slot_mem, rqct_scan.
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-----------------------------------------------
// in       | input     | in_valid/in_ready   | mode, slot, data_byte, in_sync
// out      | output    | out_valid/out_ready | commit_point, committed_advanced,
//          |           |                     | beacon_complete, regression, active_count
// cfg      | input     | cfg_valid/cfg_ready | cfg_data (quorum)
//
// Sequence: connect, disconnect, sync mark and dropped items go from idle straight to
// the finish state; a beacon byte for a connected slot adds one read-modify-write of
// the slot record. A beacon that completes and raises a slot's offset adds a scan of
// the record memory, one slot per read cycle, then a drain and a decide state. The
// single read port of the record memory is why the scan reads one slot at a time.
// Reset: slot flags, counts and committed offset clear at once; no clearing pass,
// records are always written by a connect before their contents are used.
// Stalls: one item at a time; a finished result waits in the output register and
// the next item is taken while it waits; cfg is always ready.
module replica_quorum_commit_tracker #(
    parameter int SLOTS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        mode,
    input  logic [3:0]                        slot,
    input  logic [7:0]                        data_byte,
    input  logic                              in_sync,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rqct_pkg::OFFSET_W-1:0]     commit_point,
    output logic                              committed_advanced,
    output logic                              beacon_complete,
    output logic                              regression,
    output logic [rqct_pkg::ACTIVE_W-1:0]     active_count,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rqct_pkg::QUORUM_W-1:0]     cfg_data
);
    import rqct_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RMW    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [SLOTS-1:0]    sync_reg, sync_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [QUORUM_W-1:0] quorum_reg;
    logic [OFFSET_W-1:0] committed_reg, committed_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [7:0]          byte_reg, byte_next;
    logic                adv_reg, adv_next;
    logic                cmp_reg, cmp_next;
    logic                regr_reg, regr_next;
    logic [IW-1:0]       scan_addr_reg, scan_addr_next;
    logic                pend_vld_reg, pend_vld_next;
    logic                pend_member_reg, pend_member_next;

    logic                out_valid_reg;
    logic [OFFSET_W-1:0] out_offset_reg;
    logic                out_adv_reg, out_cmp_reg, out_regr_reg;
    logic [ACTIVE_W-1:0] out_count_reg;

    logic                in_fire, in_range;
    logic [IW-1:0]       in_idx;
    logic                out_load;

    logic                mem_wr_en;
    logic [IW-1:0]       mem_wr_addr, mem_rd_addr;
    rqct_entry_t         mem_wr_data, mem_rd_data;

    rqct_scan_ctl_t      scan_ctl;
    logic [OFFSET_W-1:0] scan_min;
    logic [CW-1:0]       scan_members;

    logic [63:0]         raw;
    logic                raw_lt, raw_gt;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign in_range  = (32'(slot) < 32'(SLOTS));
    assign in_idx    = IW'(slot);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // assembled beacon, signed 64-bit against the stored offset
    assign raw    = {byte_reg, mem_rd_data.asm_bytes};
    assign raw_lt = raw[63] || (raw[62:0] < mem_rd_data.offset);
    assign raw_gt = !raw[63] && (raw[62:0] > mem_rd_data.offset);

    assign mem_rd_addr = (state_reg == ST_SCAN) ? scan_addr_reg : in_idx;

    rqct_slot_mem #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rqct_scan #(
        .CW (CW)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .offset   (mem_rd_data.offset),
        .low_mark (scan_min),
        .members  (scan_members)
    );

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        sync_next        = sync_reg;
        count_next       = count_reg;
        committed_next   = committed_reg;
        idx_next         = idx_reg;
        byte_next        = byte_reg;
        adv_next         = adv_reg;
        cmp_next         = cmp_reg;
        regr_next        = regr_reg;
        scan_addr_next   = scan_addr_reg;
        pend_vld_next    = 1'b0;
        pend_member_next = pend_member_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = idx_reg;
        mem_wr_data      = mem_rd_data;
        scan_ctl.clear   = 1'b0;
        scan_ctl.take    = pend_vld_reg;
        scan_ctl.member  = pend_member_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    idx_next   = in_idx;
                    byte_next  = data_byte;
                    adv_next   = 1'b0;
                    cmp_next   = 1'b0;
                    regr_next  = 1'b0;
                    state_next = ST_FINISH;
                    if (in_range)
                    begin
                        case (mode)
                            MODE_BEACON:
                            begin
                                // record read issued this cycle at in_idx
                                if (valid_reg[in_idx])
                                begin
                                    state_next = ST_RMW;
                                end
                            end
                            MODE_CONNECT:
                            begin
                                if (!valid_reg[in_idx])
                                begin
                                    count_next = count_reg + CW'(1);
                                end
                                valid_next[in_idx] = 1'b1;
                                sync_next[in_idx]  = in_sync;
                                mem_wr_en          = 1'b1;
                                mem_wr_addr        = in_idx;
                                mem_wr_data        = '0;
                            end
                            MODE_DISCONNECT:
                            begin
                                if (valid_reg[in_idx])
                                begin
                                    count_next         = count_reg - CW'(1);
                                    valid_next[in_idx] = 1'b0;
                                end
                            end
                            default:
                            begin
                                if (valid_reg[in_idx])
                                begin
                                    sync_next[in_idx] = in_sync;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_RMW:
            begin
                mem_wr_en  = 1'b1;
                state_next = ST_FINISH;
                if (mem_rd_data.asm_count != LAST_BYTE)
                begin
                    mem_wr_data.asm_bytes = mem_rd_data.asm_bytes
                        | (ASM_W'(byte_reg) << {mem_rd_data.asm_count, 3'b000});
                    mem_wr_data.asm_count = mem_rd_data.asm_count + ASM_CNT_W'(1);
                end
                else
                begin
                    cmp_next              = 1'b1;
                    mem_wr_data.asm_bytes = '0;
                    mem_wr_data.asm_count = '0;
                    if (raw_lt)
                    begin
                        regr_next = 1'b1;
                    end
                    else if (raw_gt)
                    begin
                        mem_wr_data.offset = raw[62:0];
                        scan_ctl.clear     = 1'b1;
                        scan_addr_next     = '0;
                        state_next         = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // one record read per cycle; accumulate in the next cycle
                pend_vld_next    = 1'b1;
                pend_member_next = valid_reg[scan_addr_reg] && sync_reg[scan_addr_reg];
                scan_addr_next   = scan_addr_reg + IW'(1);
                if (scan_addr_reg == IW'(SLOTS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if ((scan_members != '0)
                    && (32'(scan_members) >= 32'(quorum_reg))
                    && (scan_min > committed_reg))
                begin
                    committed_next = scan_min;
                    adv_next       = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            sync_reg      <= '0;
            count_reg     <= '0;
            quorum_reg    <= QUORUM_RST;
            committed_reg <= '0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            sync_reg      <= sync_next;
            count_reg     <= count_next;
            committed_reg <= committed_next;
            pend_vld_reg  <= pend_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                quorum_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        byte_reg        <= byte_next;
        adv_reg         <= adv_next;
        cmp_reg         <= cmp_next;
        regr_reg        <= regr_next;
        scan_addr_reg   <= scan_addr_next;
        pend_member_reg <= pend_member_next;
        if (out_load)
        begin
            out_offset_reg <= committed_reg;
            out_adv_reg    <= adv_reg;
            out_cmp_reg    <= cmp_reg;
            out_regr_reg   <= regr_reg;
            out_count_reg  <= ACTIVE_W'(count_reg);
        end
    end

    assign out_valid          = out_valid_reg;
    assign commit_point       = out_offset_reg;
    assign committed_advanced = out_adv_reg;
    assign beacon_complete    = out_cmp_reg;
    assign regression         = out_regr_reg;
    assign active_count       = out_count_reg;

    a_commit_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        committed_reg >= $past(committed_reg))
        else $error("committed offset fell");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("sequencer idle right after accepting an item");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(SLOTS))
        else $error("active count beyond slot count");

    a_adv_needs_beacon: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_adv_reg) |-> (out_cmp_reg && !out_regr_reg))
        else $error("advance reported without a completed raising beacon");

    a_scan_only_after_raise: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW && state_next == ST_SCAN) |-> (cmp_next && raw_gt))
        else $error("scan started without an offset raise");

endmodule

### src/rqct_slot_mem.sv
// rqct_slot_mem: per-slot record store, one write port, one registered read port.
// Depends on rqct_pkg (rqct_entry_t).
module rqct_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  rqct_pkg::rqct_entry_t wr_data,
    input  logic [AW-1:0]         rd_addr,
    output rqct_pkg::rqct_entry_t rd_data
);
    import rqct_pkg::*;

    rqct_entry_t mem [DEPTH];
    rqct_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/rqct_scan.sv
// rqct_scan: running minimum and member count over in-sync slot offsets.
// Depends on rqct_pkg (rqct_scan_ctl_t, OFFSET_W, OFFSET_MAX).
module rqct_scan #(
    parameter int CW = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rqct_pkg::rqct_scan_ctl_t          ctl,
    input  logic [rqct_pkg::OFFSET_W-1:0]     offset,
    output logic [rqct_pkg::OFFSET_W-1:0]     low_mark,
    output logic [CW-1:0]                     members
);
    import rqct_pkg::*;

    logic [OFFSET_W-1:0] min_reg;
    logic [OFFSET_W-1:0] min_next;
    logic [CW-1:0]       members_reg;
    logic [CW-1:0]       members_next;

    always_comb
    begin
        min_next     = min_reg;
        members_next = members_reg;
        if (ctl.clear)
        begin
            min_next     = OFFSET_MAX;
            members_next = '0;
        end
        else if (ctl.take && ctl.member)
        begin
            members_next = members_reg + CW'(1);
            if (offset < min_reg)
            begin
                min_next = offset;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= OFFSET_MAX;
            members_reg <= '0;
        end
        else
        begin
            min_reg     <= min_next;
            members_reg <= members_next;
        end
    end

    assign low_mark = min_reg;
    assign members  = members_reg;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for replica_quorum_commit_tracker, with a clocked driver,
// a clocked monitor and an item-level predictor of the slot table and commit offset.
// Depends on rqct_pkg and the replica_quorum_commit_tracker RTL.
module tb_top;

    import rqct_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int SCAN_CYCLES = NUM_SLOTS + 5;   // slowest item through the block
    localparam int CYCLE_LIMIT = 400000;          // generous; well above what a clean run needs
    localparam int NUM_PHASES  = 6;

    // one input item as driven on the in channel
    typedef struct {
        logic [1:0] mode;
        logic [3:0] slot;
        logic [7:0] data_byte;
        logic       in_sync;
    } tracker_item_t;

    // one result item as seen on the out channel
    typedef struct {
        logic [OFFSET_W-1:0] commit_point;
        logic                committed_advanced;
        logic                beacon_complete;
        logic                regression;
        logic [ACTIVE_W-1:0] active_count;
    } tracker_result_t;

    // ---------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ---------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [1:0]          mode      = MODE_BEACON;
    logic [3:0]          slot      = '0;
    logic [7:0]          data_byte = '0;
    logic                in_sync   = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [OFFSET_W-1:0] commit_point;
    logic                committed_advanced;
    logic                beacon_complete;
    logic                regression;
    logic [ACTIVE_W-1:0] active_count;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [QUORUM_W-1:0] cfg_data  = '0;

    replica_quorum_commit_tracker #(
        .SLOTS (NUM_SLOTS)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mode               (mode),
        .slot               (slot),
        .data_byte          (data_byte),
        .in_sync            (in_sync),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .commit_point       (commit_point),
        .committed_advanced (committed_advanced),
        .beacon_complete    (beacon_complete),
        .regression         (regression),
        .active_count       (active_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Bench state
    // ---------------------------------------------------------------------
    tracker_item_t   pending_items[$];     // items waiting for the driver
    tracker_result_t expected_commits[$];  // predicted results, oldest first

    int  items_in_flight = 0;   // queued but not yet accepted by the DUT
    int  fail_count      = 0;
    int  cycle_count     = 0;
    int  sender_idle_pct   = 37;
    int  receiver_idle_pct = 50;
    logic in_taken  = 1'b0;     // item accepted at the last rising edge
    logic cfg_taken = 1'b0;     // cfg write accepted at the last rising edge

    // Predictor's copy of the block state (all clear at reset, quorum 1)
    logic                 pred_valid [NUM_SLOTS];
    logic                 pred_sync  [NUM_SLOTS];
    logic [OFFSET_W-1:0]  pred_offset[NUM_SLOTS];
    logic [ASM_W-1:0]     pred_asm   [NUM_SLOTS];
    logic [ASM_CNT_W-1:0] pred_cnt   [NUM_SLOTS];
    logic [OFFSET_W-1:0]  pred_committed = '0;
    logic [QUORUM_W-1:0]  pred_quorum    = QUORUM_RST;

    // Stimulus planning: a rough idea of each slot, only used to steer the
    // random part toward beacons that actually move the commit point.
    logic        plan_valid [NUM_SLOTS];
    logic [63:0] plan_offset[NUM_SLOTS];
    int          plan_cnt   [NUM_SLOTS];
    logic [63:0] plan_high  = '0;
    int          beacon_rr  = 0;

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            pred_valid[i]  = 1'b0;
            pred_sync[i]   = 1'b0;
            pred_offset[i] = '0;
            pred_asm[i]    = '0;
            pred_cnt[i]    = '0;
            plan_valid[i]  = 1'b0;
            plan_offset[i] = '0;
            plan_cnt[i]    = 0;
        end
    end

    // ---------------------------------------------------------------------
    // Predictor: applies one accepted item to the shadow table and returns
    // the result the DUT must produce for it.
    // ---------------------------------------------------------------------
    function automatic tracker_result_t predict_commit(tracker_item_t it);
        tracker_result_t     res;
        logic [63:0]         raw;
        logic [OFFSET_W-1:0] lowest;
        int                  members;
        int                  active;
        int                  s;
        res.committed_advanced = 1'b0;
        res.beacon_complete    = 1'b0;
        res.regression         = 1'b0;
        s = it.slot;
        case (it.mode)
            MODE_BEACON:
            begin
                // bytes for a disconnected slot are dropped
                if (pred_valid[s])
                begin
                    if (pred_cnt[s] != LAST_BYTE)
                    begin
                        pred_asm[s] = pred_asm[s] | (ASM_W'(it.data_byte) << (8 * pred_cnt[s]));
                        pred_cnt[s] = pred_cnt[s] + 1'b1;
                    end
                    else
                    begin
                        raw = {it.data_byte, pred_asm[s]};
                        res.beacon_complete = 1'b1;
                        pred_asm[s] = '0;
                        pred_cnt[s] = '0;
                        // top bit set reads as negative: always a regression
                        if (raw[63])
                            res.regression = 1'b1;
                        else if (raw[OFFSET_W-1:0] < pred_offset[s])
                            res.regression = 1'b1;
                        else if (raw[OFFSET_W-1:0] > pred_offset[s])
                        begin
                            pred_offset[s] = raw[OFFSET_W-1:0];
                            // min over connected in-sync slots, gated by quorum
                            lowest  = OFFSET_MAX;
                            members = 0;
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                if (pred_valid[i] && pred_sync[i])
                                begin
                                    members++;
                                    if (pred_offset[i] < lowest)
                                        lowest = pred_offset[i];
                                end
                            end
                            if (members != 0 && members >= int'(pred_quorum) &&
                                lowest > pred_committed)
                            begin
                                pred_committed = lowest;
                                res.committed_advanced = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_CONNECT:
            begin
                // connect also replaces a slot that is already valid
                pred_valid[s]  = 1'b1;
                pred_sync[s]   = it.in_sync;
                pred_offset[s] = '0;
                pred_asm[s]    = '0;
                pred_cnt[s]    = '0;
            end
            MODE_DISCONNECT:
            begin
                pred_valid[s] = 1'b0;
            end
            default:
            begin
                if (pred_valid[s])
                    pred_sync[s] = it.in_sync;
            end
        endcase
        active = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (pred_valid[i])
                active++;
        res.commit_point = pred_committed;
        res.active_count = ACTIVE_W'(active);
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: inputs move on the falling edge only. A held item is never
    // touched until the monitor saw it accepted.
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin
        tracker_item_t it;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    it = pending_items.pop_front();
                    mode      <= it.mode;
                    slot      <= it.slot;
                    data_byte <= it.data_byte;
                    in_sync   <= it.in_sync;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Results are checked
    // before the item accepted at the same edge is predicted; the output is
    // registered, so it always belongs to an older item.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        tracker_item_t   it;
        tracker_result_t want;
        if (rst_n)
        begin
            in_taken  <= in_valid && in_ready;
            cfg_taken <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
                pred_quorum = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_commits.size() == 0)
                begin
                    $error("result item with nothing expected: commit_point %0h",
                           commit_point);
                    fail_count++;
                end
                else
                begin
                    want = expected_commits.pop_front();
                    if (commit_point !== want.commit_point)
                    begin
                        $error("commit_point expected %0h actual %0h",
                               want.commit_point, commit_point);
                        fail_count++;
                    end
                    if (committed_advanced !== want.committed_advanced)
                    begin
                        $error("committed_advanced expected %0b actual %0b",
                               want.committed_advanced, committed_advanced);
                        fail_count++;
                    end
                    if (beacon_complete !== want.beacon_complete)
                    begin
                        $error("beacon_complete expected %0b actual %0b",
                               want.beacon_complete, beacon_complete);
                        fail_count++;
                    end
                    if (regression !== want.regression)
                    begin
                        $error("regression expected %0b actual %0b",
                               want.regression, regression);
                        fail_count++;
                    end
                    if (active_count !== want.active_count)
                    begin
                        $error("active_count expected %0d actual %0d",
                               want.active_count, active_count);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                it.mode      = mode;
                it.slot      = slot;
                it.data_byte = data_byte;
                it.in_sync   = in_sync;
                expected_commits.push_back(predict_commit(it));
                items_in_flight--;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic queue_item(logic [1:0] m, int s, logic [7:0] b, logic sync);
        tracker_item_t it;
        it.mode      = m;
        it.slot      = 4'(s);
        it.data_byte = b;
        it.in_sync   = sync;
        pending_items.push_back(it);
        items_in_flight++;
        if (m == MODE_CONNECT)
        begin
            plan_valid[s]  = 1'b1;
            plan_offset[s] = '0;
            plan_cnt[s]    = 0;
        end
        else if (m == MODE_DISCONNECT)
            plan_valid[s] = 1'b0;
    endtask

    // eight bytes, least significant first; in_sync is don't-care here
    task automatic queue_beacon(int s, logic [63:0] value);
        for (int i = 0; i < BEACON_BYTES; i++)
            queue_item(MODE_BEACON, s, value[8*i +: 8], 1'($urandom_range(1)));
    endtask

    // mostly a connected slot, now and then any slot
    function automatic int pick_slot();
        int s;
        s = $urandom_range(NUM_SLOTS - 1);
        for (int tries = 0; tries < 4 && !plan_valid[s]; tries++)
            s = $urandom_range(NUM_SLOTS - 1);
        return s;
    endfunction

    // Beacon value: mostly climbing past everything seen so far, plus equal,
    // smaller, negative and wide random values.
    function automatic logic [63:0] next_beacon_value(int s);
        logic [63:0] v;
        int          r;
        r = $urandom_range(99);
        if (r < 45)
            v = plan_high + 64'($urandom_range(65535, 1));
        else if (r < 65)
            v = plan_offset[s] + 64'($urandom_range(255, 1));
        else if (r < 75)
            v = plan_offset[s];
        else if (r < 83)
            v = (plan_offset[s] > 64'd1000) ? plan_offset[s] - 64'($urandom_range(1000, 1))
                                            : 64'd0;
        else if (r < 90)
            v = {1'b1, 31'($urandom), $urandom};
        else if (r < 93)
            v = {1'b0, 31'($urandom), $urandom};
        else
            v = {$urandom, $urandom};
        if (plan_valid[s] && !v[63] && v > plan_offset[s])
        begin
            plan_offset[s] = v;
            if (v > plan_high)
                plan_high = v;
        end
        return v;
    endfunction

    // One random phase: reconnect a set of slots, then mostly whole beacons
    // with connect/disconnect/sync churn and stray bytes mixed in.
    task automatic queue_random_phase(int count, int churn_pct, bit connect_all);
        int start;
        int r;
        int s;
        start = items_in_flight;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (connect_all || $urandom_range(99) < 70)
                queue_item(MODE_CONNECT, i, 8'($urandom),
                           connect_all ? 1'b1 : 1'($urandom_range(9) != 0));
        while (items_in_flight - start < count)
        begin
            r = $urandom_range(99);
            if (r < churn_pct)
            begin
                case ($urandom_range(2))
                    0: queue_item(MODE_CONNECT, $urandom_range(NUM_SLOTS - 1), 8'($urandom),
                                  1'($urandom_range(4) != 0));
                    1: queue_item(MODE_DISCONNECT, pick_slot(), 8'($urandom),
                                  1'($urandom_range(1)));
                    default: queue_item(MODE_SYNC, pick_slot(), 8'($urandom),
                                        1'($urandom_range(3) != 0));
                endcase
            end
            else if (r < churn_pct + 10)
            begin
                // stray byte: breaks the framing of a live slot, dropped otherwise
                s = $urandom_range(NUM_SLOTS - 1);
                if (plan_valid[s])
                    plan_cnt[s] = (plan_cnt[s] + 1) % BEACON_BYTES;
                queue_item(MODE_BEACON, s, 8'($urandom), 1'($urandom_range(1)));
            end
            else
            begin
                if ($urandom_range(1) != 0)
                begin
                    s = beacon_rr;
                    beacon_rr = (beacon_rr + 1) % NUM_SLOTS;
                end
                else
                    s = pick_slot();
                // finish a broken frame with junk before the real beacon
                if (plan_cnt[s] != 0)
                begin
                    for (int k = plan_cnt[s]; k < BEACON_BYTES; k++)
                        queue_item(MODE_BEACON, s, 8'($urandom), 1'($urandom_range(1)));
                    plan_cnt[s] = 0;
                end
                queue_beacon(s, next_beacon_value(s));
            end
        end
    endtask

    // Block is idle once every queued item was taken and answered.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (items_in_flight != 0 || expected_commits.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_quorum(logic [QUORUM_W-1:0] q);
        cfg_data  <= q;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        int phase_quorum [NUM_PHASES];
        int phase_items  [NUM_PHASES];
        int phase_churn  [NUM_PHASES];
        phase_quorum = '{0, 16, 2, 5, 3, 1};
        phase_items  = '{100, 220, 100, 100, 100, 60};
        phase_churn  = '{25, 4, 25, 25, 25, 25};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset quorum of 1
        queue_item(MODE_BEACON, 15, 8'hFF, 1'b1);      // byte for an unconnected slot
        queue_item(MODE_SYNC, 9, 8'h00, 1'b1);         // sync mark on an unconnected slot
        queue_item(MODE_DISCONNECT, 2, 8'h00, 1'b0);   // disconnect of an unconnected slot
        queue_item(MODE_CONNECT, 0, 8'h00, 1'b1);
        queue_item(MODE_CONNECT, 15, 8'h00, 1'b0);
        queue_beacon(15, 64'hFF00_FF00_FF00_FF00);     // negative beacon, regression
        queue_beacon(0, 64'h0000_0000_0000_0100);      // raises commit with one member
        queue_item(MODE_SYNC, 0, 8'h00, 1'b0);
        queue_item(MODE_DISCONNECT, 15, 8'h00, 1'b1);
        queue_item(MODE_CONNECT, 0, 8'h00, 1'b1);      // reconnect of a live slot
        wait_drained();

        // Random phases: idle pattern A, then B, then none
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 2)
            begin
                sender_idle_pct   = 37;
                receiver_idle_pct = 50;
            end
            else if (p < 4)
            begin
                sender_idle_pct   = 50;
                receiver_idle_pct = 37;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            write_quorum(QUORUM_W'(phase_quorum[p]));
            queue_random_phase(phase_items[p], phase_churn[p], p == 1);
            wait_drained();
        end

        // Tail (quorum 1): only slot 0 stays in sync and reports the largest offset
        for (int i = 1; i < NUM_SLOTS; i++)
            queue_item(MODE_SYNC, i, 8'($urandom), 1'b0);
        queue_item(MODE_CONNECT, 0, 8'($urandom), 1'b1);
        queue_beacon(0, 64'h7FFF_FFFF_FFFF_FFFF);
        wait_drained();
        repeat (2 * SCAN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
src/rqct_pkg.sv
src/rqct_slot_mem.sv
src/rqct_scan.sv
src/replica_quorum_commit_tracker.sv
tb/sv/tb_top.sv
